@@ rtl/goldbach_prime_pair_search_assert.svh @@
// Assertion helpers shared by the goldbach pair search modules.
`ifndef GOLDBACH_PRIME_PAIR_SEARCH_ASSERT_SVH
`define GOLDBACH_PRIME_PAIR_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GPPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in goldbach pair search");

// Next-cycle implication, disabled while reset is high.
`define GPPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in goldbach pair search");

`endif

@@ rtl/gpps_pkg.sv @@
`timescale 1ns / 1ps

package gpps_pkg;

  // Width of the number and prime fields on the ports.
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_INPUT = 2'd1;
  localparam status_t ST_NO_PAIR   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_n;
    logic    init_p;
    logic    inc_p;
    logic    load_v;
    logic    sel_partner;
    logic    init_d;
    logic    step_d;
    logic    rem_start;
    logic    load_out;
    status_t code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_bad;
    logic p_over;
    logic v_lt2;
    logic v_lt4;
    logic v_even;
    logic sq_over;
    logic rem_done;
    logic rem_zero;
  } sts_t;

endpackage

@@ rtl/gpps_if.sv @@
`timescale 1ns / 1ps

// Channel carrying one number to split.
interface gpps_num_if;
  logic                          valid;
  logic                          ready;
  logic [gpps_pkg::VALUE_W-1:0]  even_number;

  modport source (output valid, output even_number, input ready);
  modport sink (input valid, input even_number, output ready);
endinterface

// Channel carrying one prime pair result.
interface gpps_pair_if;
  logic                          valid;
  logic                          ready;
  logic [gpps_pkg::VALUE_W-1:0]  smaller_prime;
  logic [gpps_pkg::VALUE_W-1:0]  larger_prime;
  gpps_pkg::status_t             status;

  modport source (output valid, output smaller_prime, output larger_prime,
                  output status, input ready);
  modport sink (input valid, input smaller_prime, input larger_prime,
                input status, output ready);
endinterface

@@ rtl/gpps_rem.sv @@
`timescale 1ns / 1ps
`include "goldbach_prime_pair_search_assert.svh"

// Iterative restoring remainder: one dividend bit per cycle.
module gpps_rem #(
  parameter int NB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [NB-1:0] divisor,
  output logic          done,
  output logic [NB-1:0] rem
);

  localparam int CW = $clog2(NB);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NB-1:0] sh;
  logic [NB:0]   shifted;
  logic [NB:0]   diff;
  logic [NB-1:0] rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted  = {rem, sh[NB-1]};
    diff     = shifted - {1'b0, divisor};
    rem_next = (shifted >= {1'b0, divisor}) ? diff[NB-1:0] : shifted[NB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NB - 1);
        rem  <= '0;
        sh   <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        sh  <= sh << 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // A new division must not start on top of one in progress.
  `GPPS_ASSERT_NOW(a_no_restart, clk, rst, start, !busy)

endmodule

@@ rtl/gpps_datapath.sv @@
`timescale 1ns / 1ps
`include "goldbach_prime_pair_search_assert.svh"

// Registers for the number, the candidate, the value under test and the divisor.
module gpps_datapath #(
  parameter int NB = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gpps_pkg::cmd_t                cmd,
  input  logic [gpps_pkg::VALUE_W-1:0]  even_number,
  output gpps_pkg::sts_t                sts,
  output logic [gpps_pkg::VALUE_W-1:0]  smaller_prime,
  output logic [gpps_pkg::VALUE_W-1:0]  larger_prime,
  output gpps_pkg::status_t             status
);

  localparam int SW = NB + 3;

  logic [NB-1:0] n;
  logic [NB-1:0] p;
  logic [NB-1:0] v;
  logic [NB-1:0] d;
  logic [SW-1:0] dsq;
  logic [NB-1:0] partner;
  logic [NB-1:0] rem;
  logic          rem_done;

  assign partner = n - p;

  gpps_rem #(.NB(NB)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rem_start),
    .dividend (v),
    .divisor  (d),
    .done     (rem_done),
    .rem      (rem)
  );

  // Working registers, stepped by the controller.
  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n <= even_number[NB-1:0];
    end
    if (cmd.init_p) begin
      p <= NB'(2);
    end else if (cmd.inc_p) begin
      p <= p + 1'b1;
    end
    if (cmd.load_v) begin
      v <= cmd.sel_partner ? partner : p;
    end
    // The square of the divisor follows it: (d+2)^2 = d^2 + 4d + 4.
    if (cmd.init_d) begin
      d   <= NB'(3);
      dsq <= SW'(9);
    end else if (cmd.step_d) begin
      d   <= d + NB'(2);
      dsq <= dsq + {1'b0, d, 2'b00} + SW'(4);
    end
  end

  // Result register; primes are zero unless a pair was found.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.code;
      if (cmd.code == gpps_pkg::ST_OK) begin
        smaller_prime <= gpps_pkg::VALUE_W'(p);
        larger_prime  <= gpps_pkg::VALUE_W'(partner);
      end else begin
        smaller_prime <= '0;
        larger_prime  <= '0;
      end
    end
  end

  // Status flags for the controller.
  always_comb begin
    sts.n_bad    = (n <= NB'(2)) || n[0];
    sts.p_over   = p > (n >> 1);
    sts.v_lt2    = v < NB'(2);
    sts.v_lt4    = v < NB'(4);
    sts.v_even   = !v[0];
    sts.sq_over  = dsq > {3'b000, v};
    sts.rem_done = rem_done;
    sts.rem_zero = (rem == '0);
  end

  // A reported pair is always ordered.
  `GPPS_ASSERT_NOW(a_pair_order, clk, rst,
                   cmd.load_out && (cmd.code == gpps_pkg::ST_OK), p <= partner)

endmodule

@@ rtl/gpps_ctrl.sv @@
`timescale 1ns / 1ps
`include "goldbach_prime_pair_search_assert.svh"

// Sequencer for the candidate scan and the trial-division prime test.
module gpps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  gpps_pkg::sts_t sts,
  output gpps_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CAND,
    S_PRIME_START,
    S_SQ_CHECK,
    S_REM_WAIT,
    S_DONE
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              phase;
  logic              phase_next;
  gpps_pkg::status_t code;
  gpps_pkg::status_t code_next;
  logic              out_valid_next;
  logic              prime_yes;
  logic              prime_no;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    phase_next = phase;
    code_next  = code;
    prime_yes  = 1'b0;
    prime_no   = 1'b0;
    cmd        = '0;
    cmd.code   = code;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_n = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.n_bad) begin
          code_next  = gpps_pkg::ST_BAD_INPUT;
          state_next = S_DONE;
        end else begin
          cmd.init_p = 1'b1;
          state_next = S_CAND;
        end
      end
      S_CAND: begin
        if (sts.p_over) begin
          code_next  = gpps_pkg::ST_NO_PAIR;
          state_next = S_DONE;
        end else begin
          cmd.load_v = 1'b1;
          phase_next = 1'b0;
          state_next = S_PRIME_START;
        end
      end
      S_PRIME_START: begin
        if (sts.v_lt2) begin
          prime_no = 1'b1;
        end else if (sts.v_lt4) begin
          prime_yes = 1'b1;
        end else if (sts.v_even) begin
          prime_no = 1'b1;
        end else begin
          cmd.init_d = 1'b1;
          state_next = S_SQ_CHECK;
        end
      end
      S_SQ_CHECK: begin
        if (sts.sq_over) begin
          prime_yes = 1'b1;
        end else begin
          cmd.rem_start = 1'b1;
          state_next    = S_REM_WAIT;
        end
      end
      S_REM_WAIT: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            prime_no = 1'b1;
          end else begin
            cmd.step_d = 1'b1;
            state_next = S_SQ_CHECK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Outcome of one prime test: test the partner, report, or move on.
    if (prime_yes) begin
      if (!phase) begin
        cmd.load_v      = 1'b1;
        cmd.sel_partner = 1'b1;
        phase_next      = 1'b1;
        state_next      = S_PRIME_START;
      end else begin
        code_next  = gpps_pkg::ST_OK;
        state_next = S_DONE;
      end
    end else if (prime_no) begin
      cmd.inc_p  = 1'b1;
      state_next = S_CAND;
    end

    out_valid_next = cmd.load_out || (out_valid && !out_ready);
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      code      <= gpps_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      code      <= code_next;
      out_valid <= out_valid_next;
    end
  end

  // The result register is never overwritten while a result still waits.
  `GPPS_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || out_ready)
  // A finished division is only reported while the controller waits for it.
  `GPPS_ASSERT_NOW(a_rem_in_wait, clk, rst, sts.rem_done, state == S_REM_WAIT)
  // An accepted number always starts a search.
  `GPPS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready,
                    state == S_CHECK)

endmodule

@@ rtl/goldbach_prime_pair_search.sv @@
`timescale 1ns / 1ps
// Channel  Role    Payload
// number   sink    even_number[15:0]
// pair     source  smaller_prime[15:0], larger_prime[15:0], status[1:0]
//
// One number is taken at a time; a rejected number goes from S_CHECK to S_DONE, and its
// result is offered once the output register is free. Each candidate needs, per odd trial
// divisor up to the square root, one remainder from the bit-serial remainder unit
// (NB = min(VALUE_BITS, 16)); the total depends on the number.
// Reset is synchronous and clears the sequencer and the result valid flag.
// A finished result waits in the output register while the next number is taken.
module goldbach_prime_pair_search #(
  parameter int VALUE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  gpps_num_if.sink   number,
  gpps_pair_if.source pair
);

  localparam int NB = (VALUE_BITS < gpps_pkg::VALUE_W) ? VALUE_BITS : gpps_pkg::VALUE_W;

  gpps_pkg::cmd_t cmd;
  gpps_pkg::sts_t sts;

  gpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (pair.valid),
    .out_ready (pair.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gpps_datapath #(.NB(NB)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .even_number   (number.even_number),
    .sts           (sts),
    .smaller_prime (pair.smaller_prime),
    .larger_prime  (pair.larger_prime),
    .status        (pair.status)
  );

endmodule

@@ test/goldbach_prime_pair_search_test.sv @@
`timescale 1ns / 1ps

module goldbach_prime_pair_search_test;

  // One result as it leaves the pair channel.
  typedef struct packed {
    logic [gpps_pkg::VALUE_W-1:0] smaller;
    logic [gpps_pkg::VALUE_W-1:0] larger;
    gpps_pkg::status_t            status;
  } prime_pair_t;

  // One row of the directed table. Rows without a typed result use the predictor.
  typedef struct packed {
    logic [gpps_pkg::VALUE_W-1:0] number;
    logic                         typed;
    prime_pair_t                  result;
  } number_row_t;

  localparam prime_pair_t NOT_TYPED = '0;
  localparam int DIRECTED_ROWS = 19;
  localparam int RANDOM_NUMBERS = 80;
  localparam int LONG_HOLD_CYCLES = 30000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  // Bad inputs, the smallest splits and the extremes of the 16-bit range.
  number_row_t directed_rows [DIRECTED_ROWS] = '{
    {16'd0,     1'b1, {16'd0, 16'd0, gpps_pkg::ST_BAD_INPUT}},
    {16'd1,     1'b1, {16'd0, 16'd0, gpps_pkg::ST_BAD_INPUT}},
    {16'd2,     1'b1, {16'd0, 16'd0, gpps_pkg::ST_BAD_INPUT}},
    {16'd3,     1'b1, {16'd0, 16'd0, gpps_pkg::ST_BAD_INPUT}},
    {16'd65535, 1'b1, {16'd0, 16'd0, gpps_pkg::ST_BAD_INPUT}},
    {16'h5555,  1'b1, {16'd0, 16'd0, gpps_pkg::ST_BAD_INPUT}},
    {16'd4,     1'b1, {16'd2, 16'd2, gpps_pkg::ST_OK}},
    {16'd6,     1'b1, {16'd3, 16'd3, gpps_pkg::ST_OK}},
    {16'd8,     1'b1, {16'd3, 16'd5, gpps_pkg::ST_OK}},
    {16'd10,    1'b1, {16'd3, 16'd7, gpps_pkg::ST_OK}},
    {16'd12,    1'b1, {16'd5, 16'd7, gpps_pkg::ST_OK}},
    {16'd128,   1'b0, NOT_TYPED},
    {16'd256,   1'b0, NOT_TYPED},
    {16'd998,   1'b0, NOT_TYPED},
    {16'hAAAA,  1'b0, NOT_TYPED},
    {16'd32768, 1'b0, NOT_TYPED},
    {16'h8002,  1'b0, NOT_TYPED},
    {16'd65532, 1'b0, NOT_TYPED},
    {16'd65534, 1'b0, NOT_TYPED}
  };

  logic clk;
  logic rst;

  gpps_num_if  number_ch ();
  gpps_pair_if pair_ch ();

  goldbach_prime_pair_search uut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .pair   (pair_ch)
  );

  prime_pair_t expected_pairs [$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Trial division: true when the value has exactly two divisors.
  function automatic bit is_prime_value(int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= v; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Smallest prime p with n - p prime as well, or an error status.
  function automatic prime_pair_t split_into_primes(logic [gpps_pkg::VALUE_W-1:0] n);
    prime_pair_t r;
    int unsigned p;
    r = '0;
    if (n <= 2 || n[0]) begin
      r.status = gpps_pkg::ST_BAD_INPUT;
      return r;
    end
    for (p = 2; p <= n / 2; p++) begin
      if (is_prime_value(p) && is_prime_value(n - p)) begin
        r.smaller = p[gpps_pkg::VALUE_W-1:0];
        r.larger  = n - p[gpps_pkg::VALUE_W-1:0];
        r.status  = gpps_pkg::ST_OK;
        return r;
      end
    end
    r.status = gpps_pkg::ST_NO_PAIR;
    return r;
  endfunction

  // Offers one number, in bursts separated by random gaps, and records the
  // expected pair once the transfer has taken place.
  task automatic send_number(input logic [gpps_pkg::VALUE_W-1:0] n, input logic typed,
                             input prime_pair_t typed_result);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        number_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    number_ch.valid       <= 1'b1;
    number_ch.even_number <= n;
    @(posedge clk);
    while (!number_ch.ready) @(posedge clk);
    expected_pairs.push_back(typed ? typed_result : split_into_primes(n));
    burst_left--;
    @(negedge clk);
  endtask

  // Random numbers: mostly small even values that finish fast, a few across
  // the full range, and some odd or too small values.
  function automatic logic [gpps_pkg::VALUE_W-1:0] random_number();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 16'($urandom_range(2, 1000) * 2);
    if (pick < 70) return 16'($urandom_range(2, 32) * 2);
    if (pick < 78) return 16'($urandom_range(2, 32767) * 2);
    if (pick < 92) return 16'($urandom_range(0, 32767) * 2 + 1);
    return 16'($urandom_range(0, 2));
  endfunction

  // Stimulus: directed table, a drain, then random numbers.
  initial begin
    int i;
    rst = 1'b1;
    number_ch.valid = 1'b0;
    number_ch.even_number = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_number(directed_rows[i].number, directed_rows[i].typed,
                  directed_rows[i].result);
    end

    // Pause until every result is back, then ask for a long receiver stall.
    number_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_pairs.size() != 0) @(negedge clk);
    hold_request = 1'b1;

    for (i = 0; i < RANDOM_NUMBERS; i++) begin
      send_number(random_number(), 1'b0, NOT_TYPED);
    end
    number_ch.valid <= 1'b0;

    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: one long hold-off when requested, otherwise a rotating stall
  // pattern that is redrawn whenever its random age runs out.
  initial begin
    int          hold_left;
    bit          hold_served;
    logic [15:0] stall_pattern;
    int          pattern_age;
    hold_left = 0;
    hold_served = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_age = 0;
    pair_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pair_ch.ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom) | 16'($urandom);
            default: stall_pattern = 16'($urandom) & 16'($urandom);
          endcase
          if (stall_pattern == 16'h0000) stall_pattern = 16'h0001;
          pattern_age = $urandom_range(32, 128);
        end
        pair_ch.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        pattern_age--;
      end
    end
  end

  // Compare every pair transfer with the oldest expectation.
  always @(posedge clk) begin
    prime_pair_t want;
    prime_pair_t got;
    if (!rst && pair_ch.valid && pair_ch.ready) begin
      got = {pair_ch.smaller_prime, pair_ch.larger_prime, pair_ch.status};
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected pair %0d + %0d, status %0d", got.smaller, got.larger,
                   got.status);
      end else begin
        want = expected_pairs.pop_front();
        if (got.smaller !== want.smaller || got.larger !== want.larger ||
            got.status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Pair mismatch: expected %0d + %0d status %0d, got %0d + %0d status %0d",
                     want.smaller, want.larger, want.status,
                     got.smaller, got.larger, got.status);
        end
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ goldbach_prime_pair_search.f @@
+incdir+rtl
rtl/gpps_pkg.sv
rtl/gpps_if.sv
rtl/gpps_rem.sv
rtl/gpps_datapath.sv
rtl/gpps_ctrl.sv
rtl/goldbach_prime_pair_search.sv
test/goldbach_prime_pair_search_test.sv
